[design/mfilt_pkg.sv]
// shared types, constants and helpers for the masked ip filter table
`default_nettype none

package mfilt_pkg;

    // table size default
    localparam int MAX_ENTRIES_DEF = 1024;

    // payload widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 32;
    localparam int OCTETS    = 4;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 10;

    // apb port widths
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FILTER_BAN = 1'b0;

    // one stored filter: octet mask kept as four bits
    typedef struct packed {
        logic              valid;
        logic [OCTETS-1:0] given;
        logic [ADDR_W-1:0] compare;
    } entry_t;

    // request presented to the shared compare unit
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [OCTETS-1:0] given;
        logic [ADDR_W-1:0] compare;
    } match_req_t;

    // expand octet flags into a byte mask
    function automatic logic [ADDR_W-1:0] octet_mask(input logic [OCTETS-1:0] given);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int k = 0; k < OCTETS; k++) begin
            m[k*8 +: 8] = {8{given[k]}};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[design/mfilt_if.sv]
// request and response channel interfaces
`default_nettype none

interface mfilt_req_if;
    logic                       valid;
    logic                       ready;
    logic [mfilt_pkg::OP_W-1:0]   op;
    logic [mfilt_pkg::ADDR_W-1:0] address;
    logic [mfilt_pkg::OCTETS-1:0] octet_given;

    modport source (output valid, output op, output address, output octet_given,
                    input ready);
    modport sink   (input valid, input op, input address, input octet_given,
                    output ready);
endinterface

interface mfilt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           blocked;
    logic [mfilt_pkg::STATUS_W-1:0] status;
    logic [mfilt_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, output blocked, output status, output slot,
                    input ready);
    modport sink   (input valid, input blocked, input status, input slot,
                    output ready);
endinterface

`default_nettype wire

[design/mfilt_store.sv]
// filter entry memory, one write and one registered read port
`default_nettype none

module mfilt_store #(
    parameter int DEPTH = mfilt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire mfilt_pkg::entry_t    wr_data,
    input  wire logic                 rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output mfilt_pkg::entry_t         rd_data
);
    import mfilt_pkg::*;

    entry_t entry_mem_reg [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/mfilt_match.sv]
// shared compare unit, one stored entry against the current request
`default_nettype none

module mfilt_match (
    input  wire mfilt_pkg::match_req_t mreq,
    input  wire mfilt_pkg::entry_t     entry,
    output logic                       hit
);
    import mfilt_pkg::*;

    logic [ADDR_W-1:0] lhs;
    logic              eq;

    // one 32-bit comparator serves both check and remove
    always_comb
    begin
        if (mreq.op == OP_CHECK)
        begin
            lhs = mreq.address & octet_mask(entry.given);
        end
        else
        begin
            lhs = mreq.compare;
        end
        eq = (lhs == entry.compare);
    end

    // per-operation match rule
    always_comb
    begin
        case (mreq.op)
            OP_CHECK:  hit = entry.valid && eq;
            OP_ADD:    hit = !entry.valid;
            OP_REMOVE: hit = entry.valid && eq && (mreq.given == entry.given);
            default:   hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[design/mfilt_apb.sv]
// apb register slave holding the filter_ban mode bit
`default_nettype none

module mfilt_apb (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mfilt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mfilt_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mfilt_pkg::APB_DATA_W-1:0] prdata,
    output logic                                  pready,
    output logic                                  filter_ban
);
    import mfilt_pkg::*;

    logic                 filter_ban_reg;
    logic                 filter_ban_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_xfer;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        filter_ban_next = filter_ban_reg;
        if (wr_xfer && (reg_idx == REG_FILTER_BAN))
        begin
            filter_ban_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_ban_reg <= 1'b1;
        end
        else
        begin
            filter_ban_reg <= filter_ban_next;
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_FILTER_BAN)
        begin
            prdata = {{(APB_DATA_W-1){1'b0}}, filter_ban_reg};
        end
    end

    assign filter_ban = filter_ban_reg;

endmodule

`default_nettype wire

[design/masked_ip_filter_table.sv]
// masked ipv4 filter table: top level with scan sequencer
//
// Requests arrive on req (op, address, octet_given) and each produces exactly
// one response on rsp (blocked, status, slot). The filter_ban mode bit is
// written through the apb port at word 0 and must only change while idle.
// Every check, add or remove walks the entry memory from slot 0 up to the
// high-water count, reading one entry per cycle through the single read port
// and testing it in one shared compare unit. The walk stops early on the
// first hit; op code 3 skips the walk and goes straight to the response.
// One request is in flight at a time, so req.ready is low from transfer
// until the response is loaded into the output register, after which the
// next transfer can follow.
// The response sits in an output register; a new request is taken while it
// waits, and a stalled receiver only holds up the following response.
// Reset clears the sequencer, the high-water count and the output register and
// sets filter_ban; the entry memory needs no clearing pass because entries at
// or above the high-water count are never read.
`default_nettype none

module masked_ip_filter_table #(
    parameter int MAX_ENTRIES = mfilt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    mfilt_req_if.sink                             req,
    mfilt_rsp_if.source                           rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mfilt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mfilt_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mfilt_pkg::APB_DATA_W-1:0] prdata,
    output logic                                  pready
);
    import mfilt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0] address_reg, address_next;
    logic [OCTETS-1:0] given_reg, given_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic              res_blocked_reg, res_blocked_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_blocked_reg, rsp_blocked_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [SLOT_W-1:0] rsp_slot_reg, rsp_slot_next;

    logic              filter_ban;
    logic [ADDR_W-1:0] req_compare;
    logic              scan_more;
    logic              hit;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    entry_t            rd_data;
    match_req_t        mreq;

    // configuration register
    mfilt_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .filter_ban (filter_ban)
    );

    // entry memory
    mfilt_store #(
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // shared compare unit
    assign req_compare = address_reg & octet_mask(given_reg);
    assign mreq        = '{op: op_reg, address: address_reg, given: given_reg,
                           compare: req_compare};

    mfilt_match u_match (
        .mreq  (mreq),
        .entry (rd_data),
        .hit   (hit)
    );

    assign scan_more = (rd_idx_reg < used_count_reg);
    assign rd_en     = (state_reg == S_SCAN) && !(chk_vld_reg && hit) && scan_more;

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.blocked = rsp_blocked_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.slot    = rsp_slot_reg;

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        address_next     = address_reg;
        given_next       = given_reg;
        rd_idx_next      = rd_idx_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        used_count_next  = used_count_reg;
        res_blocked_next = res_blocked_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_blocked_next = rsp_blocked_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_slot_next    = rsp_slot_reg;
        wr_en            = 1'b0;
        wr_addr          = found_idx_reg;
        wr_data          = '{valid: 1'b1, given: given_reg, compare: req_compare};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next          = req.op;
                    address_next     = req.address;
                    given_next       = req.octet_given;
                    rd_idx_next      = '0;
                    chk_vld_next     = 1'b0;
                    found_next       = 1'b0;
                    res_blocked_next = 1'b0;
                    res_status_next  = ST_DONE;
                    res_slot_next    = '0;
                    if ((req.op == OP_CHECK) || (req.op == OP_ADD) || (req.op == OP_REMOVE))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            // walk entries: issue one read a cycle, test the previous one
            S_SCAN:
            begin
                if (chk_vld_reg && hit)
                begin
                    found_next     = 1'b1;
                    found_idx_next = chk_idx_reg;
                    chk_vld_next   = 1'b0;
                    state_next     = S_FINISH;
                end
                else if (scan_more)
                begin
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                else if (chk_vld_reg)
                begin
                    chk_vld_next = 1'b0;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // form result and update the table
            S_FINISH:
            begin
                state_next = S_RESP;
                case (op_reg)
                    OP_CHECK:
                    begin
                        res_blocked_next = found_reg ? filter_ban : !filter_ban;
                    end
                    OP_ADD:
                    begin
                        if (found_reg)
                        begin
                            wr_en         = 1'b1;
                            res_slot_next = SLOT_W'(found_idx_reg);
                        end
                        else if (used_count_reg < CNT_W'(MAX_ENTRIES))
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = used_count_reg[IDX_W-1:0];
                            used_count_next = used_count_reg + CNT_W'(1);
                            res_slot_next   = SLOT_W'(used_count_reg[IDX_W-1:0]);
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            wr_en         = 1'b1;
                            wr_data.valid = 1'b0;
                            res_slot_next = SLOT_W'(found_idx_reg);
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_DONE;
                    end
                endcase
            end

            // hand result to the output register once it is free
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_blocked_next = res_blocked_reg;
                    rsp_status_next  = res_status_reg;
                    rsp_slot_next    = res_slot_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_CHECK;
            address_reg     <= '0;
            given_reg       <= '0;
            rd_idx_reg      <= '0;
            chk_vld_reg     <= 1'b0;
            chk_idx_reg     <= '0;
            found_reg       <= 1'b0;
            found_idx_reg   <= '0;
            used_count_reg  <= '0;
            res_blocked_reg <= 1'b0;
            res_status_reg  <= ST_DONE;
            res_slot_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_blocked_reg <= 1'b0;
            rsp_status_reg  <= ST_DONE;
            rsp_slot_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            address_reg     <= address_next;
            given_reg       <= given_next;
            rd_idx_reg      <= rd_idx_next;
            chk_vld_reg     <= chk_vld_next;
            chk_idx_reg     <= chk_idx_next;
            found_reg       <= found_next;
            found_idx_reg   <= found_idx_next;
            used_count_reg  <= used_count_next;
            res_blocked_reg <= res_blocked_next;
            res_status_reg  <= res_status_next;
            res_slot_reg    <= res_slot_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_blocked_reg <= rsp_blocked_next;
            rsp_status_reg  <= rsp_status_next;
            rsp_slot_reg    <= rsp_slot_next;
        end
    end

endmodule

`default_nettype wire

[design/mfilt_chk.sv]
// port-level assertion checker for the filter table, bound to the top level
`default_nettype none

module mfilt_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic                           rsp_blocked,
    input wire logic [mfilt_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [mfilt_pkg::SLOT_W-1:0]   rsp_slot
);
    import mfilt_pkg::*;

    // one request at a time: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another was in flight");

    // a response never appears in the cycle right after a request transfer
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_valid && req_ready))
        else $error("response appeared too soon after request");

    // failed add or remove reports no slot and no block
    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != ST_DONE)) |-> (rsp_slot == '0) && !rsp_blocked)
        else $error("failure response carries slot or blocked");

    // stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_blocked) && $stable(rsp_status) && $stable(rsp_slot)))
        else $error("stalled response changed");

endmodule

bind masked_ip_filter_table mfilt_chk u_mfilt_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_blocked (rsp.blocked),
    .rsp_status  (rsp.status),
    .rsp_slot    (rsp.slot)
);

`default_nettype wire
